// ===== hw/rtl/jts_pkg.sv =====
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types, character codes and token kinds for the JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

	localparam int POSITION_BITS = 32;
	localparam int MAX_TOKENS    = 3;
	localparam int TOK_IDX_BITS  = $clog2(MAX_TOKENS);

	typedef logic [POSITION_BITS-1:0] pos_t;

	// scan modes
	localparam logic [1:0] MODE_IDLE   = 2'd0;
	localparam logic [1:0] MODE_STRING = 2'd1;
	localparam logic [1:0] MODE_PRIM   = 2'd2;
	localparam logic [1:0] MODE_WAIT   = 2'd3;

	// token kinds
	localparam logic [3:0] TK_LBRACE   = 4'd0;
	localparam logic [3:0] TK_RBRACE   = 4'd1;
	localparam logic [3:0] TK_LBRACKET = 4'd2;
	localparam logic [3:0] TK_RBRACKET = 4'd3;
	localparam logic [3:0] TK_COMMA    = 4'd4;
	localparam logic [3:0] TK_KEY      = 4'd5;
	localparam logic [3:0] TK_PRIM     = 4'd6;
	localparam logic [3:0] TK_END      = 4'd7;
	localparam logic [3:0] TK_ERROR    = 4'd8;

	// characters
	localparam logic [7:0] CH_LBRACE   = 8'h7B;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_0        = 8'h30;
	localparam logic [7:0] CH_9        = 8'h39;
	localparam logic [7:0] CH_LC_A     = 8'h61;
	localparam logic [7:0] CH_LC_Z     = 8'h7A;
	localparam logic [7:0] CH_UC_A     = 8'h41;
	localparam logic [7:0] CH_UC_Z     = 8'h5A;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} byte_beat_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [31:0] text_offset;
		logic [31:0] text_length;
		logic        last_of_run;
	} token_beat_t;

	// all tokens caused by one byte, in emission order
	typedef struct packed {
		token_beat_t [MAX_TOKENS-1:0] tok;
		logic [TOK_IDX_BITS:0]        count;
	} token_set_t;

endpackage

// ===== hw/rtl/jts_scan.sv =====
// ----------------------------------------------------------------------------
// jts_scan
// Scanner state and the per-byte next-state and token logic.
// ----------------------------------------------------------------------------
module jts_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  jts_pkg::byte_beat_t beat,
	output jts_pkg::token_set_t tokens
);
	import jts_pkg::*;

	logic [1:0] mode_q, mode_n;
	logic       odd_q, odd_n;
	pos_t       pos_q, pos_n;
	pos_t       begin_q, begin_n;
	pos_t       plen_q, plen_n;

	logic [TOK_IDX_BITS-1:0] n;
	logic                    do_idle;
	logic [7:0]              c;
	pos_t                    nxpos;

	function automatic token_beat_t mk(logic [3:0] kind, pos_t off, pos_t len);
		token_beat_t t;
		t.token_kind  = kind;
		t.text_offset = 32'(off);
		t.text_length = 32'(len);
		t.last_of_run = 1'b0;
		return t;
	endfunction

	always_comb begin
		c       = beat.data_byte;
		mode_n  = mode_q;
		odd_n   = odd_q;
		begin_n = begin_q;
		plen_n  = plen_q;
		tokens  = '0;
		n       = '0;
		do_idle = 1'b0;
		nxpos   = pos_q + pos_t'(1);

		case (mode_q)
			MODE_IDLE: do_idle = 1'b1;
			MODE_STRING: begin
				if (c == CH_BSLASH) begin
					odd_n = ~odd_q;
				end else if (c == CH_QUOTE && !odd_q) begin
					plen_n = pos_q - begin_q;
					mode_n = MODE_WAIT;
				end else begin
					odd_n = 1'b0;
				end
			end
			MODE_PRIM: begin
				if (c inside {CH_RBRACE, CH_RBRACKET, CH_COMMA, CH_SPACE, CH_TAB}) begin
					tokens.tok[n] = mk(TK_PRIM, begin_q, pos_q - begin_q);
					n = n + 1'b1;
					mode_n  = MODE_IDLE;
					do_idle = 1'b1;
				end
			end
			MODE_WAIT: begin
				if (c inside {CH_SPACE, CH_TAB}) begin
					mode_n = MODE_WAIT;
				end else if (c == CH_COLON) begin
					tokens.tok[n] = mk(TK_KEY, begin_q, plen_q);
					n = n + 1'b1;
					mode_n = MODE_IDLE;
				end else begin
					tokens.tok[n] = mk(TK_PRIM, begin_q, plen_q);
					n = n + 1'b1;
					mode_n  = MODE_IDLE;
					do_idle = 1'b1;
				end
			end
			default: mode_n = MODE_IDLE;
		endcase

		if (do_idle) begin
			case (c)
				CH_LBRACE: begin
					tokens.tok[n] = mk(TK_LBRACE, pos_q, '0);
					n = n + 1'b1;
				end
				CH_RBRACE: begin
					tokens.tok[n] = mk(TK_RBRACE, pos_q, '0);
					n = n + 1'b1;
				end
				CH_LBRACKET: begin
					tokens.tok[n] = mk(TK_LBRACKET, pos_q, '0);
					n = n + 1'b1;
				end
				CH_RBRACKET: begin
					tokens.tok[n] = mk(TK_RBRACKET, pos_q, '0);
					n = n + 1'b1;
				end
				CH_COMMA: begin
					tokens.tok[n] = mk(TK_COMMA, pos_q, '0);
					n = n + 1'b1;
				end
				CH_QUOTE: begin
					mode_n  = MODE_STRING;
					odd_n   = 1'b0;
					begin_n = nxpos;
				end
				default: begin
					if (c inside {[CH_0:CH_9], [CH_LC_A:CH_LC_Z], [CH_UC_A:CH_UC_Z]}) begin
						mode_n  = MODE_PRIM;
						begin_n = pos_q;
					end
				end
			endcase
		end

		pos_n = nxpos;

		if (beat.final_byte) begin
			if (mode_n == MODE_STRING || mode_n == MODE_PRIM) begin
				tokens.tok[n] = mk(TK_ERROR, begin_n, nxpos - begin_n);
				n = n + 1'b1;
			end else begin
				if (mode_n == MODE_WAIT) begin
					tokens.tok[n] = mk(TK_PRIM, begin_n, plen_n);
					n = n + 1'b1;
				end
				tokens.tok[n] = mk(TK_END, nxpos, '0);
				n = n + 1'b1;
			end
			// document done: back to reset values
			mode_n  = MODE_IDLE;
			odd_n   = 1'b0;
			pos_n   = '0;
			begin_n = '0;
			plen_n  = '0;
		end

		// at most three tokens per byte, so n never wraps
		tokens.count = {1'b0, n};
		if (tokens.count != '0)
			tokens.tok[TOK_IDX_BITS'(tokens.count - 1'b1)].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			odd_q   <= 1'b0;
			pos_q   <= '0;
			begin_q <= '0;
			plen_q  <= '0;
		end else if (step) begin
			mode_q  <= mode_n;
			odd_q   <= odd_n;
			pos_q   <= pos_n;
			begin_q <= begin_n;
			plen_q  <= plen_n;
		end
	end

endmodule

// ===== hw/rtl/jts_out_buf.sv =====
// ----------------------------------------------------------------------------
// jts_out_buf
// Holds the tokens of one byte and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module jts_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  jts_pkg::token_set_t  set,
	output logic                 free,
	output logic                 valid,
	input  logic                 stall,
	output jts_pkg::token_beat_t beat
);
	import jts_pkg::*;

	token_set_t              buf_q;
	logic [TOK_IDX_BITS-1:0] rd_idx_q;
	logic                    valid_q;
	logic                    take;

	assign valid = valid_q;
	assign beat  = buf_q.tok[rd_idx_q];
	assign take  = valid_q && !stall;
	assign free  = !valid_q || (take && beat.last_of_run);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			rd_idx_q <= '0;
		end else if (load) begin
			valid_q  <= 1'b1;
			rd_idx_q <= '0;
		end else if (take) begin
			if (beat.last_of_run)
				valid_q <= 1'b0;
			else
				rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			buf_q <= set;
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n) load |-> free)
		else $error("token set loaded over undelivered tokens");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ({1'b0, rd_idx_q} < buf_q.count))
		else $error("read index past token count");
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !beat.last_of_run && !load) |=> (valid_q && rd_idx_q == $past(rd_idx_q) + 1'b1))
		else $error("token buffer failed to advance");

endmodule

// ===== hw/rtl/json_token_scanner_top.sv =====
// ----------------------------------------------------------------------------
// json_token_scanner_top
// Byte-serial JSON tokenizer: input register, scanner, token output buffer.
// ----------------------------------------------------------------------------
// The first token of a byte passes the input register, then the token register,
//   before it is valid at the output.
// Throughput: one byte per cycle while each byte causes at most one token and
//   token_stall is low; a byte with k tokens holds the single-beat port for k beats.
// Reset (arst_n low, asynchronous): scanner returns to idle at offset 0, no
//   beats are pending on either side.
module json_token_scanner_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  jts_pkg::byte_beat_t  byte_beat,
	output logic                 token_valid,
	input  logic                 token_stall,
	output jts_pkg::token_beat_t token_beat
);
	import jts_pkg::*;

	logic       s1_valid_q;
	byte_beat_t beat_s1;
	token_set_t set;
	logic       free;
	logic       go;

	// a byte with no tokens moves on regardless of the output side
	assign go         = s1_valid_q && (set.count == '0 || free);
	assign byte_stall = s1_valid_q && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (!byte_stall)
			s1_valid_q <= byte_valid;
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid)
			beat_s1 <= byte_beat;
	end

	jts_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (go),
		.beat   (beat_s1),
		.tokens (set)
	);

	jts_out_buf u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (go && set.count != '0),
		.set    (set),
		.free   (free),
		.valid  (token_valid),
		.stall  (token_stall),
		.beat   (token_beat)
	);

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !go) |=> (s1_valid_q && $stable(beat_s1)))
		else $error("held byte lost or changed");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_stall) |=> (token_valid && $stable(token_beat)))
		else $error("stalled token beat dropped or changed");
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> s1_valid_q)
		else $error("input stalled with nothing held");

endmodule

// ===== tb/tb_json_token_scanner_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_json_token_scanner_top
// Feeds JSON text byte by byte (directed corner cases, then random documents
// with some noise and truncated ones) and checks every token beat against a
// scanner model kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module tb_json_token_scanner_top;

	import jts_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 16;
	localparam int RANDOM_BYTES   = 220;
	localparam int LONG_HOLD      = 80;

	typedef struct {
		byte_beat_t beat;
		int         gap;
		logic       drain;
	} text_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	byte_beat_t  byte_beat = '0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	token_beat_t token_beat;

	text_item_t  text_q[$];
	token_beat_t token_q[$];
	token_beat_t run_q[$];
	token_beat_t want_tok;

	// scanner state as seen from the accepted bytes
	logic [1:0]  sc_mode = MODE_IDLE;
	logic        sc_bs_odd = 1'b0;
	pos_t        sc_pos = '0;
	pos_t        sc_begin = '0;
	pos_t        sc_str_len = '0;

	int          fail_cnt = 0;
	int          bytes_taken = 0;
	int          cycle_cnt = 0;
	int          idle_cycles = 0;
	int          stall_cnt = 0;
	int          hold_cnt = 0;
	int          stall_pick;
	logic        long_hold_done = 1'b0;
	logic        calm_doc = 1'b0;
	int          doc_cnt = 0;

	json_token_scanner_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_beat   (byte_beat),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_beat  (token_beat)
	);

	always #1 clk = ~clk;

	function void put_token(logic [3:0] kind, pos_t off, pos_t len);
		token_beat_t t;
		t.token_kind  = kind;
		t.text_offset = off;
		t.text_length = len;
		t.last_of_run = 1'b0;
		run_q.push_back(t);
	endfunction

	function void idle_char(logic [7:0] c, pos_t p);
		case (c)
		CH_LBRACE:   put_token(TK_LBRACE, p, '0);
		CH_RBRACE:   put_token(TK_RBRACE, p, '0);
		CH_LBRACKET: put_token(TK_LBRACKET, p, '0);
		CH_RBRACKET: put_token(TK_RBRACKET, p, '0);
		CH_COMMA:    put_token(TK_COMMA, p, '0);
		CH_QUOTE: begin
			sc_mode   = MODE_STRING;
			sc_bs_odd = 1'b0;
			sc_begin  = p + 1'b1;
		end
		default: begin
			if ((c >= CH_0 && c <= CH_9) || (c >= CH_LC_A && c <= CH_LC_Z) ||
					(c >= CH_UC_A && c <= CH_UC_Z)) begin
				sc_mode  = MODE_PRIM;
				sc_begin = p;
			end
		end
		endcase
	endfunction

	// advance the scanner by one byte and queue the tokens it causes
	function void scan_byte(byte_beat_t b);
		logic [7:0] c;
		pos_t       p;
		c = b.data_byte;
		p = sc_pos;
		run_q.delete();
		case (sc_mode)
		MODE_IDLE: idle_char(c, p);
		MODE_STRING: begin
			if (c == CH_BSLASH)
				sc_bs_odd = ~sc_bs_odd;
			else if (c == CH_QUOTE && !sc_bs_odd) begin
				sc_str_len = p - sc_begin;
				sc_mode    = MODE_WAIT;
			end else
				sc_bs_odd = 1'b0;
		end
		MODE_PRIM: begin
			if (c == CH_RBRACE || c == CH_RBRACKET || c == CH_COMMA ||
					c == CH_SPACE || c == CH_TAB) begin
				put_token(TK_PRIM, sc_begin, p - sc_begin);
				sc_mode = MODE_IDLE;
				idle_char(c, p);
			end
		end
		default: begin
			if (c == CH_COLON) begin
				put_token(TK_KEY, sc_begin, sc_str_len);
				sc_mode = MODE_IDLE;
			end else if (c != CH_SPACE && c != CH_TAB) begin
				put_token(TK_PRIM, sc_begin, sc_str_len);
				sc_mode = MODE_IDLE;
				idle_char(c, p);
			end
		end
		endcase
		sc_pos = p + 1'b1;
		if (b.final_byte) begin
			if (sc_mode == MODE_STRING || sc_mode == MODE_PRIM)
				put_token(TK_ERROR, sc_begin, sc_pos - sc_begin);
			else begin
				if (sc_mode == MODE_WAIT)
					put_token(TK_PRIM, sc_begin, sc_str_len);
				put_token(TK_END, sc_pos, '0);
			end
			sc_mode    = MODE_IDLE;
			sc_bs_odd  = 1'b0;
			sc_pos     = '0;
			sc_begin   = '0;
			sc_str_len = '0;
		end
		if (run_q.size() != 0)
			run_q[run_q.size()-1].last_of_run = 1'b1;
		foreach (run_q[i])
			token_q.push_back(run_q[i]);
	endfunction

	function automatic logic [7:0] alnum_char();
		int r;
		r = $urandom_range(0, 61);
		if (r < 10)
			return CH_0 + 8'(r);
		else if (r < 36)
			return CH_LC_A + 8'(r - 10);
		else
			return CH_UC_A + 8'(r - 36);
	endfunction

	task automatic add_byte(logic [7:0] c);
		text_item_t it;
		int r;
		it.beat.data_byte  = c;
		it.beat.final_byte = 1'b0;
		it.drain = 1'b0;
		r = $urandom_range(0, 99);
		if (calm_doc || r < 70)
			it.gap = 0;
		else if (r < 92)
			it.gap = $urandom_range(1, 3);
		else
			it.gap = $urandom_range(8, 25);
		text_q.push_back(it);
	endtask

	task automatic add_text(string s, logic fin);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
		if (fin)
			text_q[text_q.size()-1].beat.final_byte = 1'b1;
	endtask

	task automatic add_string_body();
		int r;
		repeat ($urandom_range(0, 6)) begin
			r = $urandom_range(0, 9);
			case (r)
			6: add_byte(CH_BSLASH);
			7: add_byte(CH_SPACE);
			8: begin
				add_byte(CH_BSLASH);
				add_byte(CH_QUOTE);
			end
			9: add_byte(8'($urandom_range(0, 255)) == CH_QUOTE ? CH_LC_A :
				8'($urandom_range(0, 255)));
			default: add_byte(alnum_char());
			endcase
		end
	endtask

	// mostly well-formed text with random content; some noise and truncation
	task automatic gen_document();
		int first;
		int kind;
		logic [7:0] c;
		first    = text_q.size();
		calm_doc = ($urandom_range(0, 9) < 3);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8))
				add_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 10)) begin
				kind = $urandom_range(0, 9);
				case (kind)
				0: add_byte(CH_LBRACE);
				1: add_byte(CH_RBRACE);
				2: add_byte(CH_LBRACKET);
				3: add_byte(CH_RBRACKET);
				4: add_byte(CH_COMMA);
				5, 6: begin
					add_byte(CH_QUOTE);
					add_string_body();
					add_byte(CH_QUOTE);
					if ($urandom_range(0, 2) != 0) begin
						repeat ($urandom_range(0, 2))
							add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
						add_byte(CH_COLON);
					end
				end
				7, 8: begin
					add_byte(alnum_char());
					repeat ($urandom_range(0, 5)) begin
						c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
							alnum_char();
						add_byte(c);
					end
					case ($urandom_range(0, 4))
					0: add_byte(CH_COMMA);
					1: add_byte(CH_RBRACE);
					2: add_byte(CH_RBRACKET);
					3: add_byte(CH_SPACE);
					default: add_byte(CH_TAB);
					endcase
				end
				default: add_byte($urandom_range(0, 1) ? CH_SPACE : CH_COLON);
				endcase
			end
			// document cut off inside a string or a bare primitive
			if ($urandom_range(0, 6) == 0) begin
				if ($urandom_range(0, 1)) begin
					add_byte(CH_QUOTE);
					add_string_body();
				end else
					add_byte(alnum_char());
			end
		end
		if (text_q.size() == first)
			add_byte(CH_SPACE);
		text_q[text_q.size()-1].beat.final_byte = 1'b1;
		if (doc_cnt % 6 == 5)
			text_q[first].drain = 1'b1;
		doc_cnt++;
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_beat  <= '0;
		end else begin
			if (byte_valid && !byte_stall) begin
				scan_byte(byte_beat);
				bytes_taken++;
			end
			if (!byte_valid || !byte_stall) begin
				if (text_q.size() == 0)
					byte_valid <= 1'b0;
				else if (text_q[0].gap != 0) begin
					text_q[0].gap = text_q[0].gap - 1;
					byte_valid <= 1'b0;
				end else if (text_q[0].drain && token_q.size() != 0)
					byte_valid <= 1'b0;
				else begin
					byte_beat  <= text_q[0].beat;
					byte_valid <= 1'b1;
					void'(text_q.pop_front());
				end
			end
		end
	end

	// token monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_stall <= 1'b0;
		end else begin
			if (token_valid && !token_stall) begin
				if (token_q.size() == 0) begin
					$error("unexpected token beat: kind %0d offset %0d length %0d",
						token_beat.token_kind, token_beat.text_offset, token_beat.text_length);
					fail_cnt++;
				end else begin
					want_tok = token_q.pop_front();
					if (token_beat.token_kind !== want_tok.token_kind) begin
						$error("token_kind: expected %0d, got %0d",
							want_tok.token_kind, token_beat.token_kind);
						fail_cnt++;
					end
					if (token_beat.text_offset !== want_tok.text_offset) begin
						$error("text_offset: expected %0d, got %0d",
							want_tok.text_offset, token_beat.text_offset);
						fail_cnt++;
					end
					if (token_beat.text_length !== want_tok.text_length) begin
						$error("text_length: expected %0d, got %0d",
							want_tok.text_length, token_beat.text_length);
						fail_cnt++;
					end
					if (token_beat.last_of_run !== want_tok.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d",
							want_tok.last_of_run, token_beat.last_of_run);
						fail_cnt++;
					end
				end
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				token_stall <= 1'b1;
			end else if (!long_hold_done && bytes_taken >= 120 && byte_valid) begin
				// long hold-off so the scanner backs up into its input
				long_hold_done = 1'b1;
				hold_cnt = LONG_HOLD - 1;
				token_stall <= 1'b1;
			end else if (stall_cnt != 0) begin
				stall_cnt--;
				token_stall <= 1'b1;
			end else if (cycle_cnt[8:7] == 2'b00)
				token_stall <= 1'b0;
			else begin
				stall_pick = $urandom_range(0, 99);
				if (stall_pick < 65)
					token_stall <= 1'b0;
				else begin
					stall_cnt = (stall_pick < 92) ? $urandom_range(0, 2) : $urandom_range(9, 29);
					token_stall <= 1'b1;
				end
			end
		end
	end

	// watchdog: cycles with no beat accepted on either side
	always @(posedge clk) begin
		if (arst_n) begin
			cycle_cnt++;
			if ((byte_valid && !byte_stall) || (token_valid && !token_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int directed_len;
		// skipped NUL, then key with escaped quote, every bracket, a comma and a tab,
		// and a primitive left open at the end
		add_byte(8'h00);
		add_text("{\"\\\"\"\t:[Z]9,\"\"}0", 1'b1);
		// open string at the end
		add_text("\"", 1'b1);
		// waiting string flushed by a skipped byte, then one left waiting at the end
		add_byte(8'hFF);
		add_text("\"\" #\"\"", 1'b1);
		// one byte giving primitive, comma and end
		add_text("x,", 1'b1);
		directed_len = text_q.size();
		while (text_q.size() < directed_len + RANDOM_BYTES)
			gen_document();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (text_q.size() != 0 || byte_valid)
			@(posedge clk);
		while (token_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/jts_pkg.sv
hw/rtl/jts_scan.sv
hw/rtl/jts_out_buf.sv
hw/rtl/json_token_scanner_top.sv
tb/tb_json_token_scanner_top.sv
